[hdl/e2c_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// e2c_pkg
// Shared types, constants and the microcode ROM of the epoch-seconds to
// calendar converter.
// ---------------------------------------------------------------------------
package e2c_pkg;

  // Field widths
  localparam int unsigned SecsW   = 31;
  localparam int unsigned AccW    = 32;
  localparam int unsigned YearW   = 11;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinW    = 6;
  localparam int unsigned SecW    = 6;
  localparam int unsigned ZoneW   = 4;
  localparam int unsigned RemW    = 7;
  localparam int unsigned PcW     = 4;

  // Calendar constants
  localparam logic [ZoneW-1:0]  ZONE_RESET     = 4'd8;
  localparam logic [AccW-1:0]   SECS_PER_HOUR  = 32'd3600;
  localparam logic [YearW-1:0]  EPOCH_YEAR     = 11'd1970;
  localparam logic [1:0]        EPOCH_MOD4     = 2'd2;
  localparam logic [6:0]        EPOCH_MOD100   = 7'd70;
  localparam logic [8:0]        EPOCH_MOD400   = 9'd370;
  localparam logic [6:0]        LAST_MOD100    = 7'd99;
  localparam logic [8:0]        LAST_MOD400    = 9'd399;
  localparam logic [8:0]        DAYS_PER_YEAR  = 9'd365;
  localparam logic [MonthW-1:0] MONTH_FEB      = 4'd1;
  localparam logic [MonthW-1:0] MONTH_DEC      = 4'd11;

  // Reciprocal constants: floor(2^shift / divisor), error below one quotient
  localparam logic [AccW-1:0] RECIP_60  = 32'd2290649224;
  localparam int unsigned     SHIFT_60  = 37;
  localparam logic [AccW-1:0] RECIP_24  = 32'd2863311530;
  localparam int unsigned     SHIFT_24  = 36;
  localparam logic [RemW-1:0] DIVISOR_60 = 7'd60;
  localparam logic [RemW-1:0] DIVISOR_24 = 7'd24;

  // Datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_MUL,
    OP_REM,
    OP_SPLIT,
    OP_YEAR,
    OP_MONTH,
    OP_DONE
  } e2c_op_t;

  // Constant divisor selection
  typedef enum logic {
    DIV_60,
    DIV_24
  } e2c_div_t;

  // Destination of a split remainder
  typedef enum logic [1:0] {
    DST_SEC,
    DST_MIN,
    DST_HOUR
  } e2c_dest_t;

  // Jump condition
  typedef enum logic [1:0] {
    COND_NONE,
    COND_IDLE,
    COND_WALK,
    COND_ALWAYS
  } e2c_cond_t;

  // One microcode word
  typedef struct packed {
    e2c_op_t   op;
    e2c_div_t  div;
    e2c_dest_t dest;
    e2c_cond_t cond;
    logic [PcW-1:0] target;
  } e2c_uword_t;

  // Control from sequencer to datapath
  typedef struct packed {
    e2c_op_t   op;
    e2c_div_t  div;
    e2c_dest_t dest;
    logic      load;
  } e2c_ctrl_t;

  // Status from datapath to sequencer
  typedef struct packed {
    logic walk_more;
  } e2c_stat_t;

  // Microcode program
  function automatic e2c_uword_t ucode_rom(input logic [PcW-1:0] pc);
    e2c_uword_t w;
    w = '{op: OP_IDLE, div: DIV_60, dest: DST_SEC, cond: COND_ALWAYS, target: 4'd0};
    case (pc)
      4'd0:  w = '{op: OP_IDLE,  div: DIV_60, dest: DST_SEC,  cond: COND_IDLE,   target: 4'd0};
      4'd1:  w = '{op: OP_MUL,   div: DIV_60, dest: DST_SEC,  cond: COND_NONE,   target: 4'd0};
      4'd2:  w = '{op: OP_REM,   div: DIV_60, dest: DST_SEC,  cond: COND_NONE,   target: 4'd0};
      4'd3:  w = '{op: OP_SPLIT, div: DIV_60, dest: DST_SEC,  cond: COND_NONE,   target: 4'd0};
      4'd4:  w = '{op: OP_MUL,   div: DIV_60, dest: DST_MIN,  cond: COND_NONE,   target: 4'd0};
      4'd5:  w = '{op: OP_REM,   div: DIV_60, dest: DST_MIN,  cond: COND_NONE,   target: 4'd0};
      4'd6:  w = '{op: OP_SPLIT, div: DIV_60, dest: DST_MIN,  cond: COND_NONE,   target: 4'd0};
      4'd7:  w = '{op: OP_MUL,   div: DIV_24, dest: DST_HOUR, cond: COND_NONE,   target: 4'd0};
      4'd8:  w = '{op: OP_REM,   div: DIV_24, dest: DST_HOUR, cond: COND_NONE,   target: 4'd0};
      4'd9:  w = '{op: OP_SPLIT, div: DIV_24, dest: DST_HOUR, cond: COND_NONE,   target: 4'd0};
      4'd10: w = '{op: OP_YEAR,  div: DIV_60, dest: DST_SEC,  cond: COND_WALK,   target: 4'd10};
      4'd11: w = '{op: OP_MONTH, div: DIV_60, dest: DST_SEC,  cond: COND_WALK,   target: 4'd11};
      4'd12: w = '{op: OP_DONE,  div: DIV_60, dest: DST_SEC,  cond: COND_ALWAYS, target: 4'd0};
      default: w = '{op: OP_IDLE, div: DIV_60, dest: DST_SEC, cond: COND_ALWAYS, target: 4'd0};
    endcase
    return w;
  endfunction

  // Days in a month (zero-based month), February without leap day
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] mon);
    logic [DayW-1:0] d;
    d = 5'd31;
    case (mon)
      4'd1:                   d = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
      default:                d = 5'd31;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

[hdl/e2c_seq.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// e2c_seq
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// ---------------------------------------------------------------------------
module e2c_seq import e2c_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  e2c_stat_t stat,
  output e2c_ctrl_t ctrl,
  output logic      busy
);

  logic [PcW-1:0] pc_r;
  logic [PcW-1:0] pc_nxt;
  e2c_uword_t     uw;
  logic           take_jump;

  // Fetch the current control word
  assign uw = ucode_rom(pc_r);

  // Evaluate the jump condition
  always_comb begin
    unique case (uw.cond)
      COND_NONE:   take_jump = 1'b0;
      COND_IDLE:   take_jump = !start;
      COND_WALK:   take_jump = stat.walk_more;
      COND_ALWAYS: take_jump = 1'b1;
      default:     take_jump = 1'b1;
    endcase
    pc_nxt = take_jump ? uw.target : pc_r + 4'd1;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Drive the datapath
  assign ctrl.op   = uw.op;
  assign ctrl.div  = uw.div;
  assign ctrl.dest = uw.dest;
  assign ctrl.load = (uw.op == OP_IDLE) && start;
  assign busy      = (uw.op != OP_IDLE);

endmodule
`default_nettype wire

[hdl/e2c_datapath.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// e2c_datapath
// Working registers, reciprocal multiplier, remainder and walk arithmetic,
// and the time-zone offset register.
// ---------------------------------------------------------------------------
module e2c_datapath import e2c_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  e2c_ctrl_t         ctrl,
  input  logic [SecsW-1:0]  in_epoch_seconds,
  input  logic              cfg_we,
  input  logic [ZoneW-1:0]  cfg_wdata,
  output e2c_stat_t         stat,
  output logic [YearW-1:0]  year,
  output logic [MonthW-1:0] month,
  output logic [DayW-1:0]   day_of_month,
  output logic [HourW-1:0]  hour,
  output logic [MinW-1:0]   minute,
  output logic [SecW-1:0]   second
);

  logic [ZoneW-1:0]  zone_r;
  logic [AccW-1:0]   acc_r,  acc_nxt;
  logic [AccW-1:0]   q_r,    q_nxt;
  logic [RemW-1:0]   rem_r,  rem_nxt;
  logic [SecW-1:0]   sec_r,  sec_nxt;
  logic [MinW-1:0]   min_r,  min_nxt;
  logic [HourW-1:0]  hour_r, hour_nxt;
  logic [YearW-1:0]  year_r, year_nxt;
  logic [MonthW-1:0] mon_r,  mon_nxt;
  logic [1:0]        m4_r,   m4_nxt;
  logic [6:0]        m100_r, m100_nxt;
  logic [8:0]        m400_r, m400_nxt;

  logic [2*AccW-1:0] prod;
  logic [AccW-1:0]   recip;
  logic [AccW-1:0]   qd;
  logic [AccW-1:0]   rem_full;
  logic [RemW-1:0]   divisor;
  logic              fix;
  logic [RemW-1:0]   rem_fixed;
  logic              leap;
  logic [8:0]        ylen;
  logic [DayW-1:0]   mlen;
  logic              year_more;
  logic              month_more;

  // Hold the zone offset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= ZONE_RESET;
    end else if (cfg_we) begin
      zone_r <= cfg_wdata;
    end
  end

  // Shared arithmetic
  always_comb begin
    recip     = (ctrl.div == DIV_60) ? RECIP_60 : RECIP_24;
    divisor   = (ctrl.div == DIV_60) ? DIVISOR_60 : DIVISOR_24;
    prod      = 64'(acc_r) * 64'(recip);
    qd        = (ctrl.div == DIV_60) ? ((q_r << 6) - (q_r << 2)) : ((q_r << 4) + (q_r << 3));
    rem_full  = acc_r - qd;
    fix       = (rem_r >= divisor);
    rem_fixed = fix ? (rem_r - divisor) : rem_r;
    leap      = ((m4_r == 2'd0) && (m100_r != 7'd0)) || (m400_r == 9'd0);
    ylen      = DAYS_PER_YEAR + 9'(leap);
    mlen      = month_days(mon_r) + 5'((mon_r == MONTH_FEB) && leap);
    year_more  = (acc_r >= 32'(ylen));
    month_more = (mon_r < MONTH_DEC) && (acc_r >= 32'(mlen));
  end

  // Next-state of the working registers
  always_comb begin
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    year_nxt = year_r;
    mon_nxt  = mon_r;
    m4_nxt   = m4_r;
    m100_nxt = m100_r;
    m400_nxt = m400_r;
    stat.walk_more = 1'b0;
    unique case (ctrl.op)
      OP_IDLE: begin
        // Start a transaction: apply the offset and reset the walk
        if (ctrl.load) begin
          acc_nxt  = {1'b0, in_epoch_seconds} + 32'(zone_r) * SECS_PER_HOUR;
          year_nxt = EPOCH_YEAR;
          mon_nxt  = '0;
          m4_nxt   = EPOCH_MOD4;
          m100_nxt = EPOCH_MOD100;
          m400_nxt = EPOCH_MOD400;
        end
      end
      OP_MUL: begin
        // Quotient estimate, at most one short
        q_nxt = (ctrl.div == DIV_60) ? AccW'(prod >> SHIFT_60) : AccW'(prod >> SHIFT_24);
      end
      OP_REM: begin
        rem_nxt = rem_full[RemW-1:0];
      end
      OP_SPLIT: begin
        // Correct the estimate and drop the remainder into its field
        acc_nxt = fix ? (q_r + 32'd1) : q_r;
        case (ctrl.dest)
          DST_SEC:  sec_nxt  = rem_fixed[SecW-1:0];
          DST_MIN:  min_nxt  = rem_fixed[MinW-1:0];
          DST_HOUR: hour_nxt = rem_fixed[HourW-1:0];
          default:  sec_nxt  = sec_r;
        endcase
      end
      OP_YEAR: begin
        stat.walk_more = year_more;
        if (year_more) begin
          acc_nxt  = acc_r - 32'(ylen);
          year_nxt = year_r + 11'd1;
          m4_nxt   = m4_r + 2'd1;
          m100_nxt = (m100_r == LAST_MOD100) ? 7'd0 : m100_r + 7'd1;
          m400_nxt = (m400_r == LAST_MOD400) ? 9'd0 : m400_r + 9'd1;
        end
      end
      OP_MONTH: begin
        stat.walk_more = month_more;
        if (month_more) begin
          acc_nxt = acc_r - 32'(mlen);
          mon_nxt = mon_r + 4'd1;
        end
      end
      OP_DONE: begin
        stat.walk_more = 1'b0;
      end
      default: begin
        stat.walk_more = 1'b0;
      end
    endcase
  end

  // Register the payload
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    sec_r  <= sec_nxt;
    min_r  <= min_nxt;
    hour_r <= hour_nxt;
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    m4_r   <= m4_nxt;
    m100_r <= m100_nxt;
    m400_r <= m400_nxt;
  end

  // Present the result fields
  assign year         = year_r;
  assign month        = mon_r + 4'd1;
  assign day_of_month = acc_r[DayW-1:0] + 5'd1;
  assign hour         = hour_r;
  assign minute       = min_r;
  assign second       = sec_r;

endmodule
`default_nettype wire

[hdl/epoch_seconds_to_calendar.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since 1970-01-01 UTC plus a whole-hour zone offset into
// Gregorian year, month, day, hour, minute and second.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The result
// appears on the out_ ports for exactly one cycle with out_valid high,
// after the run has walked Y whole years from 1970 (0..68) and M whole
// months in the final year (0..11). The year walk handles one year per
// cycle in a single microcode step; the three divisions ahead of it each
// run as multiply, remainder and split steps on one shared reciprocal
// multiplier. busy falls the cycle after the strobe, so the next start may
// follow at once; a new transaction is taken only once the last is done.
// The receiver cannot stall: the out_ fields hold their values only until
// the next transaction is accepted.
// cfg_wdata written with cfg_we sets the zone offset (reset value 8 hours);
// write it only while busy is low.
module epoch_seconds_to_calendar import e2c_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [SecsW-1:0]  in_epoch_seconds,
  input  logic              cfg_we,
  input  logic [ZoneW-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [YearW-1:0]  out_year,
  output logic [MonthW-1:0] out_month,
  output logic [DayW-1:0]   out_day_of_month,
  output logic [HourW-1:0]  out_hour,
  output logic [MinW-1:0]   out_minute,
  output logic [SecW-1:0]   out_second
);

  e2c_ctrl_t ctrl;
  e2c_stat_t stat;

  // Sequencer
  e2c_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // Datapath
  e2c_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .in_epoch_seconds (in_epoch_seconds),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .stat             (stat),
    .year             (out_year),
    .month            (out_month),
    .day_of_month     (out_day_of_month),
    .hour             (out_hour),
    .minute           (out_minute),
    .second           (out_second)
  );

  // Strobe the result on the final step
  assign out_valid = (ctrl.op == OP_DONE);

  // Accepted transaction starts the run
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Result strobe only inside a run, and for one cycle
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy && !ctrl.load))
    else $error("result strobe outside a run");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  // Month, hour, minute and second in calendar range, day nonzero, on delivery
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 &&
                   out_day_of_month >= 5'd1 && out_hour <= 5'd23 &&
                   out_minute <= 6'd59 && out_second <= 6'd59))
    else $error("result field out of calendar range");

endmodule
`default_nettype wire
